// ===== rtl/assert_macros.svh =====
// Assertion helpers for the RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a property on every rising edge of clk, off during reset.
`define PRMF_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Check that a condition holds on every rising edge, also during reset.
`define PRMF_ASSERT_ALWAYS(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ===== rtl/prmf_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// prmf_pkg
// Types and constants of the push-relabel max-flow block.
// ----------------------------------------------------------------------------
package prmf_pkg;

    localparam int NV = 16;              // vertices held in the matrix
    localparam int VW = 4;               // vertex index width
    localparam int AW = 2 * VW;          // matrix address width
    localparam int MD = NV * NV;         // matrix entries
    localparam int QD = 1024;            // active queue depth
    localparam int QW = 10;              // queue index width
    localparam int CW = 16;              // capacity width
    localparam int FW = CW + 1;          // flow width (signed)
    localparam int RW = CW + 2;          // residual width (signed)
    localparam int EW = 32;              // excess width
    localparam int HW = 6;               // label width
    localparam int NW = 5;               // vertex count width
    localparam int BW = 21;              // served counter width

    localparam logic [EW-1:0] SRC_EXCESS = 32'h7FFF_FFFF;
    localparam logic [BW-1:0] RUN_BUDGET = 21'h10_0000;
    localparam logic [NW-1:0] MIN_COUNT  = 5'd2;
    localparam logic [NW-1:0] MAX_COUNT  = 5'd16;

    typedef enum logic [1:0] {
        OP_WRITE = 2'd0,
        OP_RUN   = 2'd1,
        OP_READ  = 2'd2,
        OP_NONE  = 2'd3
    } op_t;

    typedef enum logic [1:0] {
        CFG_VCOUNT = 2'd0,
        CFG_SOURCE = 2'd1,
        CFG_SINK   = 2'd2,
        CFG_SPARE  = 2'd3
    } cfg_idx_t;

    typedef enum logic [3:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_RDW,
        ST_RUNCLR,
        ST_INIT,
        ST_PRD,
        ST_PCALC,
        ST_PWR1,
        ST_PWR2,
        ST_SRCEND,
        ST_POP,
        ST_POPW,
        ST_RRD,
        ST_RCALC,
        ST_RAPPLY,
        ST_REQ
    } state_t;

    typedef struct packed {
        logic clr_sweep;
        logic wr_cap;
        logic rd_flow;
        logic rd_done;
        logic res_zero;
        logic run_start;
        logic run_clr;
        logic init_src;
        logic p_calc;
        logic p_wr1;
        logic p_wr2;
        logic v_next;
        logic wb_ex;
        logic pop;
        logic pop_ld;
        logic r_start;
        logic r_calc;
        logic r_apply;
        logic requeue;
        logic set_ovf;
    } cmd_t;

    typedef struct packed {
        logic sweep_last;
        logic v_last;
        logic push_ok;
        logic run_bad;
        logic fifo_empty;
        logic budget_hit;
        logic out_free;
    } sts_t;

endpackage
`default_nettype wire

// ===== rtl/prmf_if.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// prmf_item_if / prmf_result_if
// Valid/ready channels for input items and result items.
// ----------------------------------------------------------------------------
interface prmf_item_if;
    logic        valid;
    logic        ready;
    logic [1:0]  operation;
    logic [3:0]  row_vertex;
    logic [3:0]  column_vertex;
    logic [15:0] capacity_value;

    modport source (output valid, operation, row_vertex, column_vertex, capacity_value,
                    input ready);
    modport sink   (input valid, operation, row_vertex, column_vertex, capacity_value,
                    output ready);
endinterface

interface prmf_result_if;
    logic               valid;
    logic               ready;
    logic signed [16:0] flow_value;
    logic               status;

    modport source (output valid, flow_value, status, input ready);
    modport sink   (input valid, flow_value, status, output ready);
endinterface
`default_nettype wire

// ===== rtl/prmf_ctrl.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// prmf_ctrl
// Sequencer: steps the datapath through loads, reads and max-flow runs.
// ----------------------------------------------------------------------------
module prmf_ctrl (
    input  wire logic            clk,
    input  wire logic            rst_n,
    input  wire logic            item_valid,
    input  wire logic [1:0]      item_op,
    output logic                 item_ready,
    input  wire prmf_pkg::sts_t  sts,
    output prmf_pkg::cmd_t       cmd
);

    prmf_pkg::state_t state_reg, state_next;
    logic             srcph_reg, srcph_next;
    logic             acc;

    assign item_ready = (state_reg == prmf_pkg::ST_IDLE) && sts.out_free;
    assign acc        = item_valid && item_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= prmf_pkg::ST_CLEAR;
            srcph_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            srcph_reg <= srcph_next;
        end
    end

    // next state
    always_comb
    begin
        state_next = state_reg;
        srcph_next = srcph_reg;
        case (state_reg)
            prmf_pkg::ST_CLEAR:
                if (sts.sweep_last) state_next = prmf_pkg::ST_IDLE;
            prmf_pkg::ST_IDLE:
            begin
                if (acc)
                begin
                    case (prmf_pkg::op_t'(item_op))
                        prmf_pkg::OP_RUN:  state_next = prmf_pkg::ST_RUNCLR;
                        prmf_pkg::OP_READ: state_next = prmf_pkg::ST_RDW;
                        default:           state_next = prmf_pkg::ST_IDLE;
                    endcase
                end
            end
            prmf_pkg::ST_RDW:    state_next = prmf_pkg::ST_IDLE;
            prmf_pkg::ST_RUNCLR:
                if (sts.sweep_last) state_next = prmf_pkg::ST_INIT;
            prmf_pkg::ST_INIT:
            begin
                if (sts.run_bad)
                begin
                    state_next = prmf_pkg::ST_IDLE;
                end
                else
                begin
                    state_next = prmf_pkg::ST_PRD;
                    srcph_next = 1'b1;
                end
            end
            prmf_pkg::ST_PRD:    state_next = prmf_pkg::ST_PCALC;
            prmf_pkg::ST_PCALC:
            begin
                if (sts.push_ok)
                    state_next = prmf_pkg::ST_PWR1;
                else if (!sts.v_last)
                    state_next = prmf_pkg::ST_PRD;
                else if (srcph_reg)
                    state_next = prmf_pkg::ST_SRCEND;
                else
                    state_next = prmf_pkg::ST_RRD;
            end
            prmf_pkg::ST_PWR1:   state_next = prmf_pkg::ST_PWR2;
            prmf_pkg::ST_PWR2:
            begin
                if (!sts.v_last)
                    state_next = prmf_pkg::ST_PRD;
                else if (srcph_reg)
                    state_next = prmf_pkg::ST_SRCEND;
                else
                    state_next = prmf_pkg::ST_RRD;
            end
            prmf_pkg::ST_SRCEND: state_next = prmf_pkg::ST_POP;
            prmf_pkg::ST_POP:
            begin
                if (sts.fifo_empty || sts.budget_hit)
                    state_next = prmf_pkg::ST_IDLE;
                else
                    state_next = prmf_pkg::ST_POPW;
            end
            prmf_pkg::ST_POPW:
            begin
                state_next = prmf_pkg::ST_PRD;
                srcph_next = 1'b0;
            end
            prmf_pkg::ST_RRD:    state_next = prmf_pkg::ST_RCALC;
            prmf_pkg::ST_RCALC:
                state_next = sts.v_last ? prmf_pkg::ST_RAPPLY : prmf_pkg::ST_RRD;
            prmf_pkg::ST_RAPPLY: state_next = prmf_pkg::ST_REQ;
            prmf_pkg::ST_REQ:    state_next = prmf_pkg::ST_POP;
            default:             state_next = prmf_pkg::ST_IDLE;
        endcase
    end

    // outputs
    always_comb
    begin
        cmd = '0;
        case (state_reg)
            prmf_pkg::ST_CLEAR:  cmd.clr_sweep = 1'b1;
            prmf_pkg::ST_IDLE:
            begin
                if (acc)
                begin
                    case (prmf_pkg::op_t'(item_op))
                        prmf_pkg::OP_WRITE:
                        begin
                            cmd.wr_cap   = 1'b1;
                            cmd.res_zero = 1'b1;
                        end
                        prmf_pkg::OP_RUN:  cmd.run_start = 1'b1;
                        prmf_pkg::OP_READ: cmd.rd_flow   = 1'b1;
                        default:           cmd.res_zero  = 1'b1;
                    endcase
                end
            end
            prmf_pkg::ST_RDW:    cmd.rd_done = 1'b1;
            prmf_pkg::ST_RUNCLR: cmd.run_clr = 1'b1;
            prmf_pkg::ST_INIT:
            begin
                if (sts.run_bad) cmd.res_zero = 1'b1;
                else             cmd.init_src = 1'b1;
            end
            prmf_pkg::ST_PCALC:
            begin
                cmd.p_calc = 1'b1;
                if (!sts.push_ok)
                begin
                    cmd.v_next  = 1'b1;
                    cmd.r_start = sts.v_last && !srcph_reg;
                end
            end
            prmf_pkg::ST_PWR1:   cmd.p_wr1 = 1'b1;
            prmf_pkg::ST_PWR2:
            begin
                cmd.p_wr2   = 1'b1;
                cmd.v_next  = 1'b1;
                cmd.r_start = sts.v_last && !srcph_reg;
            end
            prmf_pkg::ST_SRCEND: cmd.wb_ex = 1'b1;
            prmf_pkg::ST_POP:
            begin
                if (sts.fifo_empty)
                begin
                    cmd.res_zero = 1'b1;
                end
                else if (sts.budget_hit)
                begin
                    cmd.set_ovf  = 1'b1;
                    cmd.res_zero = 1'b1;
                end
                else
                begin
                    cmd.pop = 1'b1;
                end
            end
            prmf_pkg::ST_POPW:   cmd.pop_ld = 1'b1;
            prmf_pkg::ST_RCALC:
            begin
                cmd.r_calc = 1'b1;
                cmd.v_next = 1'b1;
            end
            prmf_pkg::ST_RAPPLY: cmd.r_apply = 1'b1;
            prmf_pkg::ST_REQ:
            begin
                cmd.requeue = 1'b1;
                cmd.wb_ex   = 1'b1;
            end
            default:             cmd = '0;
        endcase
    end

endmodule
`default_nettype wire

// ===== rtl/prmf_dp.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// prmf_dp
// Datapath: matrices, labels, excess, active queue and result register.
// ----------------------------------------------------------------------------
module prmf_dp (
    input  wire logic                               clk,
    input  wire logic                               rst_n,
    input  wire prmf_pkg::cmd_t                     cmd,
    output prmf_pkg::sts_t                          sts,
    input  wire logic                               cfg_we,
    input  wire logic [1:0]                         cfg_index,
    input  wire logic [prmf_pkg::NW-1:0]            cfg_data,
    input  wire logic [prmf_pkg::VW-1:0]            in_row,
    input  wire logic [prmf_pkg::VW-1:0]            in_col,
    input  wire logic [prmf_pkg::CW-1:0]            in_cap,
    input  wire logic                               out_ready,
    output logic                                    out_valid,
    output logic signed [prmf_pkg::FW-1:0]          out_flow,
    output logic                                    out_status
);

    // configuration
    logic [prmf_pkg::NW-1:0] vc_reg;
    logic [prmf_pkg::VW-1:0] src_reg, snk_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vc_reg  <= 5'd16;
            src_reg <= 4'd0;
            snk_reg <= 4'd15;
        end
        else if (cfg_we)
        begin
            case (prmf_pkg::cfg_idx_t'(cfg_index))
                prmf_pkg::CFG_VCOUNT: vc_reg  <= cfg_data;
                prmf_pkg::CFG_SOURCE: src_reg <= cfg_data[prmf_pkg::VW-1:0];
                prmf_pkg::CFG_SINK:   snk_reg <= cfg_data[prmf_pkg::VW-1:0];
                default:              vc_reg  <= vc_reg;
            endcase
        end
    end

    logic [prmf_pkg::NW-1:0] n_run;
    always_comb
    begin
        if (vc_reg < prmf_pkg::MIN_COUNT)      n_run = prmf_pkg::MIN_COUNT;
        else if (vc_reg > prmf_pkg::MAX_COUNT) n_run = prmf_pkg::MAX_COUNT;
        else                                   n_run = vc_reg;
    end

    // loop registers
    logic [prmf_pkg::VW-1:0]   u_reg, v_reg;
    logic [prmf_pkg::EW-1:0]   cur_ex_reg;
    logic [prmf_pkg::RW-1:0]   amt_reg;
    logic signed [prmf_pkg::FW-1:0] fnew_reg;
    logic [prmf_pkg::HW-1:0]   lowest_reg;
    logic [prmf_pkg::AW-1:0]   sweep_reg;
    logic [prmf_pkg::QW-1:0]   head_reg;
    logic [prmf_pkg::QW:0]     cnt_reg;
    logic [prmf_pkg::BW-1:0]   served_reg;
    logic                      ovf_reg;

    logic [prmf_pkg::EW-1:0]   ex_arr [prmf_pkg::NV];
    logic [prmf_pkg::HW-1:0]   h_arr  [prmf_pkg::NV];

    // memories
    logic [prmf_pkg::CW-1:0]        cap_mem  [prmf_pkg::MD];
    logic signed [prmf_pkg::FW-1:0] flow_mem [prmf_pkg::MD];
    logic [prmf_pkg::VW-1:0]        fifo_mem [prmf_pkg::QD];
    logic [prmf_pkg::CW-1:0]        cap_q;
    logic signed [prmf_pkg::FW-1:0] flow_q;
    logic [prmf_pkg::VW-1:0]        fifo_q;

    logic [prmf_pkg::AW-1:0] uv_addr, vu_addr, in_addr, flow_raddr;
    logic [prmf_pkg::AW-1:0] cap_waddr, flow_waddr;
    logic [prmf_pkg::CW-1:0] cap_wdata;
    logic signed [prmf_pkg::FW-1:0] flow_wdata;
    logic                    cap_we, flow_we;

    assign uv_addr    = {u_reg, v_reg};
    assign vu_addr    = {v_reg, u_reg};
    assign in_addr    = {in_row, in_col};
    assign flow_raddr = cmd.rd_flow ? in_addr : uv_addr;

    always_comb
    begin
        cap_we    = cmd.clr_sweep || cmd.wr_cap;
        cap_waddr = cmd.wr_cap ? in_addr : sweep_reg;
        cap_wdata = cmd.wr_cap ? in_cap : '0;
        flow_we   = cmd.clr_sweep || cmd.run_clr || cmd.p_wr1 || cmd.p_wr2;
        if (cmd.p_wr1)
        begin
            flow_waddr = uv_addr;
            flow_wdata = fnew_reg;
        end
        else if (cmd.p_wr2)
        begin
            flow_waddr = vu_addr;
            flow_wdata = -fnew_reg;
        end
        else
        begin
            flow_waddr = sweep_reg;
            flow_wdata = '0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cap_we) cap_mem[cap_waddr] <= cap_wdata;
        cap_q <= cap_mem[uv_addr];
    end

    always_ff @(posedge clk)
    begin
        if (flow_we) flow_mem[flow_waddr] <= flow_wdata;
        flow_q <= flow_mem[flow_raddr];
    end

    // residual and push decision for edge (u, v)
    logic signed [prmf_pkg::RW-1:0] resid;
    logic                           r_pos, ex_pos, h_ok, push_ok;
    logic [prmf_pkg::HW-1:0]        hu, hv;
    logic [prmf_pkg::RW-1:0]        amt;
    logic [prmf_pkg::EW-1:0]        resid_w;

    assign hu      = h_arr[u_reg];
    assign hv      = h_arr[v_reg];
    assign resid   = $signed({2'b00, cap_q}) - $signed({flow_q[prmf_pkg::FW-1], flow_q});
    assign r_pos   = !resid[prmf_pkg::RW-1] && (resid != '0);
    assign ex_pos  = cur_ex_reg != '0;
    assign h_ok    = (hu == hv + 6'd1) || (u_reg == src_reg);
    assign push_ok = ex_pos && h_ok && r_pos && (v_reg != u_reg);
    assign resid_w = {{(prmf_pkg::EW-prmf_pkg::RW){1'b0}}, resid};
    assign amt     = (cur_ex_reg < resid_w) ? cur_ex_reg[prmf_pkg::RW-1:0] : resid;

    // queue
    logic                    enq, enq_full;
    logic [prmf_pkg::VW-1:0] enq_val;
    logic [prmf_pkg::QW-1:0] tail;

    assign enq_full = cnt_reg[prmf_pkg::QW];
    assign tail     = head_reg + cnt_reg[prmf_pkg::QW-1:0];
    assign enq      = (cmd.p_wr1 && v_reg != src_reg && v_reg != snk_reg)
                   || (cmd.requeue && ex_pos);
    assign enq_val  = cmd.p_wr1 ? v_reg : u_reg;

    always_ff @(posedge clk)
    begin
        if (enq && !enq_full) fifo_mem[tail] <= enq_val;
        if (cmd.pop) fifo_q <= fifo_mem[head_reg];
    end

    logic v_last;
    assign v_last = ({1'b0, v_reg} == n_run - 5'd1);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sweep_reg  <= '0;
            head_reg   <= '0;
            cnt_reg    <= '0;
            served_reg <= '0;
            ovf_reg    <= 1'b0;
            u_reg      <= '0;
            v_reg      <= '0;
        end
        else
        begin
            if (cmd.clr_sweep || cmd.run_clr) sweep_reg <= sweep_reg + 8'd1;
            if (cmd.run_start)
            begin
                head_reg   <= '0;
                cnt_reg    <= '0;
                served_reg <= '0;
                ovf_reg    <= 1'b0;
            end
            if (cmd.set_ovf) ovf_reg <= 1'b1;
            if (enq)
            begin
                if (enq_full) ovf_reg <= 1'b1;
                else          cnt_reg <= cnt_reg + 11'd1;
            end
            if (cmd.pop)
            begin
                head_reg   <= head_reg + 10'd1;
                cnt_reg    <= cnt_reg - 11'd1;
                served_reg <= served_reg + 21'd1;
            end
            if (cmd.init_src)
            begin
                u_reg <= src_reg;
                v_reg <= '0;
            end
            if (cmd.pop_ld)
            begin
                u_reg <= fifo_q;
                v_reg <= '0;
            end
            if (cmd.v_next) v_reg <= v_last ? '0 : v_reg + 4'd1;
        end
    end

    // excess, labels and per-vertex working values
    always_ff @(posedge clk)
    begin
        if (cmd.run_start)
        begin
            for (int i = 0; i < prmf_pkg::NV; i++)
            begin
                ex_arr[i] <= '0;
                h_arr[i]  <= '0;
            end
        end
        if (cmd.init_src)
        begin
            cur_ex_reg       <= prmf_pkg::SRC_EXCESS;
            h_arr[src_reg]   <= {1'b0, n_run};
        end
        if (cmd.pop_ld) cur_ex_reg <= ex_arr[fifo_q];
        if (cmd.p_calc)
        begin
            amt_reg  <= amt;
            fnew_reg <= flow_q + $signed(amt[prmf_pkg::FW-1:0]);
        end
        if (cmd.p_wr1)
        begin
            cur_ex_reg    <= cur_ex_reg - {{(prmf_pkg::EW-prmf_pkg::RW){1'b0}}, amt_reg};
            ex_arr[v_reg] <= ex_arr[v_reg] + {{(prmf_pkg::EW-prmf_pkg::RW){1'b0}}, amt_reg};
        end
        if (cmd.wb_ex) ex_arr[u_reg] <= cur_ex_reg;
        if (cmd.r_start) lowest_reg <= {n_run, 1'b0};
        if (cmd.r_calc && r_pos && hv < lowest_reg) lowest_reg <= hv;
        if (cmd.r_apply && ex_pos && !(lowest_reg < hu)) h_arr[u_reg] <= lowest_reg + 6'd1;
    end

    // result register
    logic out_valid_reg;
    logic signed [prmf_pkg::FW-1:0] out_flow_reg;
    logic out_status_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (cmd.res_zero || cmd.rd_done)
            out_valid_reg <= 1'b1;
        else if (out_ready)
            out_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (cmd.res_zero || cmd.rd_done)
        begin
            out_flow_reg   <= cmd.rd_done ? flow_q : '0;
            out_status_reg <= ovf_reg || cmd.set_ovf;
        end
    end

    assign out_valid  = out_valid_reg;
    assign out_flow   = out_flow_reg;
    assign out_status = out_status_reg;

    always_comb
    begin
        sts.sweep_last = (sweep_reg == 8'hFF);
        sts.v_last     = v_last;
        sts.push_ok    = push_ok;
        sts.run_bad    = ({1'b0, src_reg} >= n_run) || ({1'b0, snk_reg} >= n_run);
        sts.fifo_empty = (cnt_reg == '0);
        sts.budget_hit = (served_reg >= prmf_pkg::RUN_BUDGET);
        sts.out_free   = !out_valid_reg || out_ready;
    end

endmodule
`default_nettype wire

// ===== rtl/push_relabel_max_flow.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// push_relabel_max_flow
// FIFO push-relabel maximum flow over a 16x16 capacity matrix.
// ----------------------------------------------------------------------------
// Usage:
//  item channel: one beat per operation. Write beats load one capacity entry,
//  run beats compute max flow from source_vertex to sink_vertex over the
//  first vertex_count vertices, read beats fetch one flow entry.
//  result channel: exactly one beat per item; flow_value carries the flow
//  for reads and zero otherwise, status is the overflow flag (queue full or
//  serve budget spent) of the latest run.
//  cfg port: cfg_we/cfg_index/cfg_data write vertex_count, source_vertex,
//  sink_vertex; write only while the block is idle.
// Sequence: a write's result is registered in the cycle after acceptance; a
//  read first registers the flow entry, then the result. A run clears the flow
//  matrix, tries edges, pushes, relabels by scanning the vertices and serves
//  the queue: every matrix access goes through the single read port of the
//  capacity and flow memories. One item is in work at a time.
// Reset: a clearing pass zeroes both matrices; item.ready stays low.
// Stall: the result register holds a beat until taken; a new item is taken
//  in the cycle the held result leaves, else the block waits.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module push_relabel_max_flow (
    input  wire logic        clk,
    input  wire logic        rst_n,
    prmf_item_if.sink        item,
    prmf_result_if.source    result,
    input  wire logic        cfg_we,
    input  wire logic [1:0]  cfg_index,
    input  wire logic [4:0]  cfg_data
);

    prmf_pkg::cmd_t cmd;
    prmf_pkg::sts_t sts;

    // sequencer
    prmf_ctrl u_ctrl (
        .clk        (clk),
        .rst_n      (rst_n),
        .item_valid (item.valid),
        .item_op    (item.operation),
        .item_ready (item.ready),
        .sts        (sts),
        .cmd        (cmd)
    );

    // storage and arithmetic
    prmf_dp u_dp (
        .clk        (clk),
        .rst_n      (rst_n),
        .cmd        (cmd),
        .sts        (sts),
        .cfg_we     (cfg_we),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data),
        .in_row     (item.row_vertex),
        .in_col     (item.column_vertex),
        .in_cap     (item.capacity_value),
        .out_ready  (result.ready),
        .out_valid  (result.valid),
        .out_flow   (result.flow_value),
        .out_status (result.status)
    );

    // a new item is only taken when the result register can hold its beat
    `PRMF_ASSERT(a_ready_room, item.ready |-> (!result.valid || result.ready), "ready with full result")
    // a write answers on the next cycle with zero flow
    `PRMF_ASSERT(a_write_result, (item.valid && item.ready && item.operation == prmf_pkg::OP_WRITE) |=> (result.valid && result.flow_value == 17'sd0), "write result missing")
    // a read keeps the block busy for its memory access
    `PRMF_ASSERT(a_read_busy, (item.valid && item.ready && item.operation == prmf_pkg::OP_READ) |=> !item.ready, "read not busy")

endmodule
`default_nettype wire

// ===== tb/prmf_flow_checker.sv =====
// ----------------------------------------------------------------------------
// prmf_flow_checker
// Watches the item, result and register ports of the max-flow block, computes
// the expected result of every accepted item with its own push-relabel solver,
// and compares each result beat field by field.
// ----------------------------------------------------------------------------
module prmf_flow_checker
    import prmf_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    prmf_item_if        itm,
    prmf_result_if      res,
    input  logic        cfg_we,
    input  logic [1:0]  cfg_index,
    input  logic [4:0]  cfg_data,
    output int          errors,
    output int          pending
);

    typedef struct {
        logic signed [FW-1:0] flow;
        logic                 ovf;
    } flow_result_t;

    flow_result_t flow_expect_q[$];

    int        cap_mx[MD];
    int        flow_mx[MD];
    int        label[NV];
    longint    excess[NV];
    int        active_q[$];
    logic      ovf_flag;
    int        vcount_reg;
    int        src_reg;
    int        sink_reg;
    int        n_run;
    int        s_run;
    int        t_run;

    task automatic report_mismatch(input string what);
        $display("MISMATCH at %0t: %s", $realtime, what);
        errors++;
    endtask

    function automatic void enqueue_active(input int v);
        if (active_q.size() >= QD)
            ovf_flag = 1'b1;
        else
            active_q.push_back(v);
    endfunction

    function automatic void push_edge(input int u, input int v);
        longint r;
        longint amt;
        if (excess[u] <= 0)
            return;
        if (label[u] != label[v] + 1 && u != s_run)
            return;
        r = longint'(cap_mx[u*NV+v]) - longint'(flow_mx[u*NV+v]);
        if (r <= 0)
            return;
        amt = (excess[u] < r) ? excess[u] : r;
        flow_mx[u*NV+v] += int'(amt);
        flow_mx[v*NV+u] -= int'(amt);
        excess[u] -= amt;
        excess[v] += amt;
        if (v != s_run && v != t_run)
            enqueue_active(v);
    endfunction

    function automatic void relabel_vertex(input int u);
        int lowest;
        lowest = 2 * n_run;
        if (excess[u] <= 0)
            return;
        for (int v = 0; v < n_run; v++)
            if (longint'(cap_mx[u*NV+v]) - longint'(flow_mx[u*NV+v]) > 0
                && label[v] < lowest)
                lowest = label[v];
        if (lowest < label[u])
            return;
        label[u] = lowest + 1;
    endfunction

    function automatic void solve_max_flow();
        int served;
        int u;
        served = 0;
        for (int i = 0; i < MD; i++)
            flow_mx[i] = 0;
        for (int i = 0; i < NV; i++)
        begin
            label[i]  = 0;
            excess[i] = 0;
        end
        active_q.delete();
        ovf_flag = 1'b0;
        n_run = (vcount_reg < 2) ? 2 : ((vcount_reg > NV) ? NV : vcount_reg);
        s_run = src_reg;
        t_run = sink_reg;
        if (s_run >= n_run || t_run >= n_run)
            return;
        excess[s_run] = 64'd2147483647;
        label[s_run]  = n_run;
        for (int v = 0; v < n_run; v++)
            push_edge(s_run, v);
        while (active_q.size() > 0)
        begin
            if (served >= int'(RUN_BUDGET))
            begin
                ovf_flag = 1'b1;
                break;
            end
            served++;
            u = active_q.pop_front();
            for (int v = 0; v < n_run; v++)
                push_edge(u, v);
            relabel_vertex(u);
            if (excess[u] > 0)
                enqueue_active(u);
        end
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        flow_result_t want;
        flow_result_t got;
        int addr;
        if (!rst_n)
        begin
            for (int i = 0; i < MD; i++)
            begin
                cap_mx[i]  = 0;
                flow_mx[i] = 0;
            end
            ovf_flag   = 1'b0;
            vcount_reg = 16;
            src_reg    = 0;
            sink_reg   = 15;
            flow_expect_q.delete();
            errors  <= 0;
            pending <= 0;
        end
        else
        begin
            if (cfg_we)
            begin
                case (cfg_idx_t'(cfg_index))
                    CFG_VCOUNT: vcount_reg = cfg_data;
                    CFG_SOURCE: src_reg    = cfg_data[3:0];
                    CFG_SINK:   sink_reg   = cfg_data[3:0];
                    default: ;
                endcase
            end
            if (itm.valid && itm.ready)
            begin
                addr = {itm.row_vertex, itm.column_vertex};
                want.flow = '0;
                case (op_t'(itm.operation))
                    OP_WRITE: cap_mx[addr] = itm.capacity_value;
                    OP_RUN:   solve_max_flow();
                    OP_READ:  want.flow = flow_mx[addr][FW-1:0];
                    default: ;
                endcase
                want.ovf = ovf_flag;
                flow_expect_q.push_back(want);
            end
            if (res.valid && res.ready)
            begin
                got.flow = res.flow_value;
                got.ovf  = res.status;
                if (flow_expect_q.size() == 0)
                    report_mismatch("result beat with nothing expected");
                else
                begin
                    want = flow_expect_q.pop_front();
                    if (got.flow !== want.flow)
                        report_mismatch($sformatf("flow_value %0d, expected %0d",
                                                  got.flow, want.flow));
                    if (got.ovf !== want.ovf)
                        report_mismatch($sformatf("status %0b, expected %0b",
                                                  got.ovf, want.ovf));
                end
            end
            pending <= flow_expect_q.size();
        end
    end

endmodule

// ===== tb/tb_top.sv =====
// ----------------------------------------------------------------------------
// tb_top
// Stimulus and verdict for the push-relabel max-flow block: loads small
// graphs, runs max flow, reads flow entries back under varied handshake
// pressure; the checker beside the block predicts and compares every beat.
// ----------------------------------------------------------------------------
module tb_top;
    import prmf_pkg::*;

    logic       clk = 1'b0;
    logic       rst_n;
    logic       cfg_we;
    logic [1:0] cfg_index;
    logic [4:0] cfg_data;
    int         fail_count;
    int         exp_pending;
    int         send_idle_pct;
    int         recv_stall_pct;
    int         rand_items;

    prmf_item_if   itm ();
    prmf_result_if res ();

    always #4 clk = ~clk;

    push_relabel_max_flow dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .item      (itm),
        .result    (res),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    prmf_flow_checker chk (
        .clk       (clk),
        .rst_n     (rst_n),
        .itm       (itm),
        .res       (res),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .errors    (fail_count),
        .pending   (exp_pending)
    );

    // Result side back-pressure; stall_pct is set per phase.
    always @(posedge clk)
        res.ready <= ($urandom_range(99) >= recv_stall_pct);

    // Offer one beat and hold it until taken. Ready is sampled at the falling
    // edge: it only moves at rising edges, so this is its value at acceptance.
    task automatic send_beat(input op_t op, input int row, input int col,
                             input int capv);
        logic rdy;
        while ($urandom_range(99) < send_idle_pct)
        begin
            itm.valid <= 1'b0;
            @(posedge clk);
        end
        itm.valid          <= 1'b1;
        itm.operation      <= op;
        itm.row_vertex     <= row[3:0];
        itm.column_vertex  <= col[3:0];
        itm.capacity_value <= capv[15:0];
        do
        begin
            @(negedge clk);
            rdy = itm.ready;
            @(posedge clk);
        end
        while (!rdy);
    endtask

    // Register writes only with the block drained; a short settle first.
    task automatic set_graph_regs(input int vc, input int src, input int snk);
        itm.valid <= 1'b0;
        @(posedge clk);
        while (exp_pending != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
        cfg_we    <= 1'b1;
        cfg_index <= CFG_VCOUNT;
        cfg_data  <= vc[4:0];
        @(posedge clk);
        cfg_index <= CFG_SOURCE;
        cfg_data  <= src[4:0];
        @(posedge clk);
        cfg_index <= CFG_SINK;
        cfg_data  <= snk[4:0];
        @(posedge clk);
        cfg_we    <= 1'b0;
        @(posedge clk);
    endtask

    // Vertex index mostly inside the active graph, sometimes anywhere.
    function automatic int pick_vertex(input int n);
        if ($urandom_range(9) == 0 || n < 2)
            return $urandom_range(15);
        return $urandom_range(n - 1);
    endfunction

    // One graph: registers, a batch of capacity loads, a run, some reads,
    // with a little noise mixed in.
    task automatic random_graph();
        int n;
        int w;
        int capv;
        int sel;
        sel = $urandom_range(99);
        if (sel < 70)
            n = $urandom_range(2, 8);
        else if (sel < 85)
            n = 16;
        else
            n = $urandom_range(31);
        set_graph_regs(n, pick_vertex(n > 16 ? 16 : n), pick_vertex(n > 16 ? 16 : n));
        w = $urandom_range(3, 10);
        repeat (w)
        begin
            sel = $urandom_range(99);
            capv = (sel < 20) ? 65535 : ((sel < 30) ? 0 : $urandom_range(65535));
            if ($urandom_range(19) == 0)
                send_beat(OP_NONE, $urandom_range(15), $urandom_range(15),
                          $urandom_range(65535));
            else
            begin
                send_beat(OP_WRITE, pick_vertex(n), pick_vertex(n), capv);
                rand_items++;
            end
        end
        send_beat(OP_RUN, $urandom_range(15), $urandom_range(15), $urandom_range(65535));
        rand_items++;
        repeat ($urandom_range(3, 6))
        begin
            send_beat(OP_READ, pick_vertex(n), pick_vertex(n), $urandom_range(65535));
            rand_items++;
        end
    endtask

    initial
    begin
        rst_n              = 1'b0;
        itm.valid          <= 1'b0;
        itm.operation      <= OP_NONE;
        itm.row_vertex     <= '0;
        itm.column_vertex  <= '0;
        itm.capacity_value <= '0;
        cfg_we             <= 1'b0;
        cfg_index          <= CFG_VCOUNT;
        cfg_data           <= '0;
        send_idle_pct      = 0;
        recv_stall_pct     = 0;
        rand_items         = 0;
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;

        // Matrix clearing pass after reset holds ready low.
        do
            @(negedge clk);
        while (!itm.ready);
        @(posedge clk);

        // Directed: a small graph with full and tiny capacities.
        set_graph_regs(4, 0, 3);
        send_beat(OP_WRITE, 0, 1, 65535);
        send_beat(OP_WRITE, 0, 2, 1);
        send_beat(OP_WRITE, 1, 3, 40000);
        send_beat(OP_WRITE, 2, 3, 7);
        send_beat(OP_WRITE, 1, 2, 65535);
        send_beat(OP_WRITE, 15, 15, 0);
        send_beat(OP_RUN, 0, 0, 0);
        send_beat(OP_READ, 0, 1, 0);
        send_beat(OP_READ, 1, 0, 0);         // reverse edge, negative flow
        send_beat(OP_READ, 2, 3, 65535);
        send_beat(OP_NONE, 15, 15, 65535);   // unused code: no effect
        send_beat(OP_READ, 15, 15, 0);
        // vertex count below the minimum acts as two
        set_graph_regs(0, 0, 1);
        send_beat(OP_RUN, 0, 0, 0);
        send_beat(OP_READ, 0, 1, 0);
        // count above the matrix acts as the full matrix
        set_graph_regs(31, 15, 0);
        send_beat(OP_WRITE, 15, 0, 65535);
        send_beat(OP_RUN, 0, 0, 0);
        send_beat(OP_READ, 15, 0, 0);
        send_beat(OP_READ, 0, 15, 0);
        // source outside the active vertices: run only clears
        set_graph_regs(2, 5, 1);
        send_beat(OP_RUN, 0, 0, 0);
        send_beat(OP_READ, 15, 0, 0);
        // source equal to sink
        set_graph_regs(1, 1, 1);
        send_beat(OP_RUN, 0, 0, 0);
        send_beat(OP_READ, 0, 1, 0);

        // Random graphs over four idling phases.
        for (int ph = 0; ph < 4; ph++)
        begin
            send_idle_pct  = (ph == 1 || ph == 3) ? 53 : 0;
            recv_stall_pct = (ph == 2 || ph == 3) ? 53 : 0;
            if (ph == 3)
            begin
                send_idle_pct  = 13;
                recv_stall_pct = 13;
            end
            while (rand_items < 28 * (ph + 1))
                random_graph();
        end

        itm.valid <= 1'b0;
        @(posedge clk);
        while (exp_pending != 0)
            @(posedge clk);
        repeat (20) @(posedge clk);
        if (fail_count == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

    // Hard stop far beyond the slowest correct run.
    initial
    begin
        #400000000;
        $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule
